FILE: rtl/i2c_slave_transaction_fsm_assert.svh
// assertion macros for the i2c slave transaction block
// expects clk_i and rst_ni in the scope of the user
`ifndef I2C_SLAVE_TRANSACTION_FSM_ASSERT_SVH
`define I2C_SLAVE_TRANSACTION_FSM_ASSERT_SVH

// same-cycle implication
`define I2CS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cs assertion failed");

// next-cycle implication
`define I2CS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cs assertion failed");

`endif

FILE: rtl/i2cs_pkg.sv
// shared types and codes of the i2c slave transaction block
// no dependencies
package i2cs_pkg;

  localparam logic [1:0] CMD_NONE          = 2'd0;
  localparam logic [1:0] CMD_ACK           = 2'd1;
  localparam logic [1:0] CMD_COMPLETE      = 2'd2;
  localparam logic [1:0] CMD_NACK_COMPLETE = 2'd3;

  localparam logic [2:0] RES_UNKNOWN   = 3'd0;
  localparam logic [2:0] RES_OK        = 3'd1;
  localparam logic [2:0] RES_OVERFLOW  = 3'd2;
  localparam logic [2:0] RES_COLLISION = 3'd3;
  localparam logic [2:0] RES_BUSERR    = 3'd4;
  localparam logic [2:0] RES_FAIL      = 3'd5;
  localparam logic [2:0] RES_ABORTED   = 3'd6;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic       bus_error;
    logic       collision;
    logic       addr_irq;
    logic       addr_match;
    logic       data_irq;
    logic       master_reads;
    logic       nack_received;
    logic [7:0] rx_byte;
    logic       abort_set;
    logic [2:0] buf_index;
    logic [7:0] buf_value;
  } req_t;

  typedef struct packed {
    logic [1:0] bus_command;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [2:0] rx_index;
    logic [7:0] rx_byte_out;
    logic       stop_irq_enabled;
    logic       clear_apif;
    logic       busy_res;
    logic [2:0] result_code;
    logic [3:0] received_count;
    logic [3:0] sent_count;
  } rsp_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] result;
    logic       abort_pend;
    logic       stop_irq;
  } flags_t;

endpackage

FILE: rtl/i2cs_if.sv
// valid/ready channels of the i2c slave transaction block
// depends on i2cs_pkg
interface i2cs_req_if import i2cs_pkg::*; ();
  logic valid;
  logic ready;
  req_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

interface i2cs_rsp_if import i2cs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

FILE: rtl/i2c_slave_transaction_fsm.sv
// i2c slave transaction control: top level with input and result registers
// depends on i2cs_pkg, i2cs_if, i2cs_ram, i2cs_step and the assertion header
//
// usage:
//   req_i carries one beat per bus event (req_type 0) or send buffer load
//   (req_type 1); rsp_o returns exactly one result beat for every request.
//   both are valid/ready channels, a beat moves when valid and ready are high.
// path: a request accepted on req_i passes the input register, one step of
//   decode logic and the result register before it is presented on rsp_o.
// throughput: one request per cycle while rsp_o is not held; the step reads
//   the send buffer ram through its registered port, addressed in the cycle
//   before with the next send count, and a same-cycle load there is forwarded.
// stall: while rsp_o is held, a result waits in the result register and one
//   more request is held in the input register; req_i.ready then drops.
// reset: counts, busy, result, abort and stop enable clear, both registers
//   are empty; send buffer entries hold nothing until loaded.
// `include "i2c_slave_transaction_fsm_assert.svh"
`include "i2c_slave_transaction_fsm_assert.svh"
module i2c_slave_transaction_fsm import i2cs_pkg::*; #(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  i2cs_req_if.sink   req_i,
  i2cs_rsp_if.source rsp_o
);

  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int TCW = $clog2(TX_DEPTH + 1);
  localparam int AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic           in_valid_q;
  req_t           in_q;
  logic           out_valid_q;
  rsp_t           rsp_q;
  flags_t         flags_q, flags_d, step_flags;
  logic [RCW-1:0] rx_cnt_q, rx_cnt_d, step_rx_cnt;
  logic [TCW-1:0] tx_cnt_q, tx_cnt_d, step_tx_cnt;
  rsp_t           step_rsp;
  logic           adv;
  logic           proc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     ram_rdata;
  logic           byp_hit_q, byp_hit_d;
  logic [7:0]     byp_data_q;
  logic [7:0]     tx_data;

  assign adv         = !out_valid_q || rsp_o.ready;
  assign proc        = in_valid_q && adv;
  assign req_i.ready = !in_valid_q || adv;

  assign wr_en   = proc && (in_q.req_type == REQ_LOAD) && (32'(in_q.buf_index) < TX_DEPTH);
  assign wr_addr = AW'(in_q.buf_index);

  always_comb begin
    flags_d  = proc ? step_flags  : flags_q;
    rx_cnt_d = proc ? step_rx_cnt : rx_cnt_q;
    tx_cnt_d = proc ? step_tx_cnt : tx_cnt_q;
  end

  // read in the cycle before, with the next send count
  assign rd_addr   = tx_cnt_d[AW-1:0];
  assign byp_hit_d = wr_en && (wr_addr == rd_addr);
  assign tx_data   = byp_hit_q ? byp_data_q : ram_rdata;

  i2cs_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_send_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_q.buf_value),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  i2cs_step #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_step (
    .item_i    (in_q),
    .flags_i   (flags_q),
    .rx_cnt_i  (rx_cnt_q),
    .tx_cnt_i  (tx_cnt_q),
    .tx_data_i (tx_data),
    .flags_o   (step_flags),
    .rx_cnt_o  (step_rx_cnt),
    .tx_cnt_o  (step_tx_cnt),
    .rsp_o     (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      rx_cnt_q    <= '0;
      tx_cnt_q    <= '0;
      byp_hit_q   <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      flags_q   <= flags_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_cnt_q  <= tx_cnt_d;
      byp_hit_q <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.beat;
    end
    if (proc) begin
      rsp_q <= step_rsp;
    end
    byp_data_q <= in_q.buf_value;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.beat  = rsp_q;

  `I2CS_ASSERT_NXT(a_in_held, in_valid_q && !adv, in_valid_q)
  `I2CS_ASSERT_IMP(a_rx_cnt_range, 1'b1, rx_cnt_q <= RCW'(RX_DEPTH))
  `I2CS_ASSERT_IMP(a_tx_cnt_range, 1'b1, tx_cnt_q <= TCW'(TX_DEPTH))
  `I2CS_ASSERT_IMP(a_tx_ack, out_valid_q && rsp_q.tx_valid, rsp_q.bus_command == CMD_ACK)
  `I2CS_ASSERT_IMP(a_rx_cmd, out_valid_q && rsp_q.rx_valid, rsp_q.bus_command == CMD_ACK || rsp_q.bus_command == CMD_COMPLETE)
  `I2CS_ASSERT_IMP(a_stop_ready, out_valid_q && rsp_q.clear_apif, !rsp_q.busy_res && rsp_q.result_code == RES_OK)

endmodule

FILE: rtl/i2cs_ram.sv
// generic single write port ram with registered read
// no dependencies
module i2cs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/i2cs_step.sv
// event decode and state update for one beat
// depends on i2cs_pkg
module i2cs_step import i2cs_pkg::*; #(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 8,
  localparam int RCW = $clog2(RX_DEPTH + 1),
  localparam int TCW = $clog2(TX_DEPTH + 1)
) (
  input  req_t           item_i,
  input  flags_t         flags_i,
  input  logic [RCW-1:0] rx_cnt_i,
  input  logic [TCW-1:0] tx_cnt_i,
  input  logic [7:0]     tx_data_i,
  output flags_t         flags_o,
  output logic [RCW-1:0] rx_cnt_o,
  output logic [TCW-1:0] tx_cnt_o,
  output rsp_t           rsp_o
);

  logic       abort_now;
  logic [1:0] cmd;
  logic       txv;
  logic [7:0] txb;
  logic       rxv;
  logic [2:0] rxi;
  logic [7:0] rxb;
  logic       clr;

  always_comb begin
    abort_now = flags_i.abort_pend | item_i.abort_set;
    flags_o   = flags_i;
    flags_o.abort_pend = abort_now;
    rx_cnt_o  = rx_cnt_i;
    tx_cnt_o  = tx_cnt_i;
    cmd = CMD_NONE;
    txv = 1'b0;
    txb = 8'd0;
    rxv = 1'b0;
    rxi = 3'd0;
    rxb = 8'd0;
    clr = 1'b0;
    if (item_i.req_type == REQ_LOAD) begin
      // buffer write happens outside
    end else if (item_i.bus_error) begin
      rx_cnt_o = '0;
      tx_cnt_o = '0;
      flags_o.result = RES_BUSERR;
      flags_o.busy   = 1'b0;
    end else if (item_i.collision) begin
      rx_cnt_o = '0;
      tx_cnt_o = '0;
      flags_o.result = RES_COLLISION;
      flags_o.busy   = 1'b0;
    end else if (item_i.addr_irq && item_i.addr_match) begin
      if (abort_now) begin
        cmd = CMD_COMPLETE;
        flags_o.result     = RES_ABORTED;
        flags_o.busy       = 1'b0;
        flags_o.abort_pend = 1'b0;
      end else begin
        cmd = CMD_ACK;
        flags_o.busy     = 1'b1;
        flags_o.result   = RES_UNKNOWN;
        flags_o.stop_irq = 1'b0;
        rx_cnt_o = '0;
        tx_cnt_o = '0;
      end
    end else if (item_i.addr_irq) begin
      // stop condition
      clr = 1'b1;
      flags_o.stop_irq = 1'b0;
      flags_o.result   = RES_OK;
      flags_o.busy     = 1'b0;
    end else if (item_i.data_irq) begin
      if (item_i.master_reads) begin
        if ((tx_cnt_i != '0) && item_i.nack_received) begin
          cmd = CMD_COMPLETE;
          flags_o.result = RES_OK;
          flags_o.busy   = 1'b0;
        end else if (tx_cnt_i < TCW'(TX_DEPTH)) begin
          cmd = CMD_ACK;
          txv = 1'b1;
          txb = tx_data_i;
          tx_cnt_o = tx_cnt_i + TCW'(1);
        end else begin
          cmd = CMD_COMPLETE;
          flags_o.result = RES_OVERFLOW;
          flags_o.busy   = 1'b0;
        end
      end else begin
        flags_o.stop_irq = 1'b1;
        if (rx_cnt_i < RCW'(RX_DEPTH)) begin
          rxv = 1'b1;
          rxi = 3'(rx_cnt_i);
          rxb = item_i.rx_byte;
          rx_cnt_o = rx_cnt_i + RCW'(1);
          if (abort_now) begin
            cmd = CMD_COMPLETE;
            flags_o.result     = RES_ABORTED;
            flags_o.busy       = 1'b0;
            flags_o.abort_pend = 1'b0;
          end else begin
            cmd = CMD_ACK;
          end
        end else begin
          cmd = CMD_NACK_COMPLETE;
          flags_o.result = RES_OVERFLOW;
          flags_o.busy   = 1'b0;
        end
      end
    end else begin
      flags_o.result = RES_FAIL;
      flags_o.busy   = 1'b0;
    end
  end

  always_comb begin
    rsp_o.bus_command      = cmd;
    rsp_o.tx_valid         = txv;
    rsp_o.tx_byte          = txb;
    rsp_o.rx_valid         = rxv;
    rsp_o.rx_index         = rxi;
    rsp_o.rx_byte_out      = rxb;
    rsp_o.stop_irq_enabled = flags_o.stop_irq;
    rsp_o.clear_apif       = clr;
    rsp_o.busy_res         = flags_o.busy;
    rsp_o.result_code      = flags_o.result;
    rsp_o.received_count   = 4'(rx_cnt_o);
    rsp_o.sent_count       = 4'(tx_cnt_o);
  end

endmodule
